>>> rtl/jdc_pkg.sv
// Shared types, constants and helpers for the joystick dead zone and clamp block.
// No dependencies; used by jdc_divsqrt and joystick_deadzone_clamp_core.
package jdc_pkg;

    localparam int DEAD_EDGE    = 8;
    localparam int DEAD_SHIFT   = 6;
    localparam int FRAC_BITS    = 8;
    localparam int MAG_LIMIT    = 64;
    localparam int MAG_LIMIT_SQ = MAG_LIMIT * MAG_LIMIT;
    localparam int MAG_Q        = MAG_LIMIT << FRAC_BITS;
    localparam int DIV_STEPS    = 29;
    localparam int SQRT_STEPS   = 15;

    typedef struct packed {
        logic start;
        logic op_sqrt;
    } jdc_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } jdc_stat_t;

    // dead zone: |v| below DEAD_EDGE -> 0, otherwise |v| - DEAD_SHIFT
    function automatic logic [6:0] dz_mag(input logic [7:0] v);
        logic signed [8:0] s;
        logic signed [8:0] m;
        s = $signed({v[7], v});
        if (s <= 9'(-DEAD_EDGE))
        begin
            m = -s - 9'(DEAD_SHIFT);
        end
        else if (s >= 9'(DEAD_EDGE))
        begin
            m = s - 9'(DEAD_SHIFT);
        end
        else
        begin
            m = '0;
        end
        return m[6:0];
    endfunction

endpackage

>>> rtl/jdc_divsqrt.sv
// Iterative restoring divider / integer square root on one shared subtract-compare.
// Depends on jdc_pkg (command and status structs, step counts).
module jdc_divsqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  jdc_pkg::jdc_cmd_t   cmd,
    input  logic [28:0]         opnd_a,
    input  logic [14:0]         opnd_d,
    output jdc_pkg::jdc_stat_t  stat,
    output logic [28:0]         result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        op_reg, op_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [17:0] rem_reg, rem_next;
    logic [29:0] rad_reg, rad_next;
    logic [28:0] acc_reg, acc_next;
    logic [14:0] div_reg, div_next;

    logic [17:0] step_a;
    logic [17:0] step_b;
    logic [17:0] step_diff;
    logic [17:0] step_sel;
    logic        step_ge;

    // shared subtract-compare
    always_comb
    begin
        step_a    = op_reg ? {rem_reg[15:0], rad_reg[29:28]} : {2'b00, rem_reg[15:0]};
        step_b    = op_reg ? {1'b0, acc_reg[14:0], 2'b01} : {3'b000, div_reg};
        step_ge   = (step_a >= step_b);
        step_diff = step_a - step_b;
        step_sel  = step_ge ? step_diff : step_a;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        acc_next  = acc_reg;
        div_next  = div_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op_sqrt;
            cnt_next  = cmd.op_sqrt ? 5'(jdc_pkg::SQRT_STEPS - 1) : 5'(jdc_pkg::DIV_STEPS - 1);
            rem_next  = cmd.op_sqrt ? '0 : opnd_a[17:0];
            rad_next  = {1'b0, opnd_a};
            acc_next  = '0;
            div_next  = opnd_d;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[27:0], step_ge};
            rem_next = op_reg ? step_sel : {step_sel[16:0], 1'b0};
            rad_next = {rad_reg[27:0], 2'b00};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        rad_reg <= rad_next;
        acc_reg <= acc_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("start while engine not free");
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("engine stopped without done");
`endif

endmodule

>>> rtl/joystick_deadzone_clamp_core.sv
// Joystick dead zone and radial clamp, top level. Depends on jdc_pkg, jdc_divsqrt.
// Within a magnitude of 64 one poll takes one 15-step root, beyond it two 29-step divides
// and two 15-step roots, all on the one subtract-compare unit in jdc_divsqrt. One poll at a
// time: the next beat waits until the sequencer is idle and the last result is loaded to
// the output; it may wait while a result sits at output under an output stall.
// Reset (rst_n, async low) clears the sequencer, output valid and the previous buttons.
module joystick_deadzone_clamp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [7:0]  stick_x,
    input  logic signed [7:0]  stick_y,
    input  logic [15:0]        buttons,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [7:0]  raw_x,
    output logic signed [7:0]  raw_y,
    output logic signed [15:0] eff_x,
    output logic signed [15:0] eff_y,
    output logic [14:0]        magnitude,
    output logic [15:0]        pressed,
    output logic [15:0]        held
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MAG  = 3'd3;
    localparam logic [2:0] S_DX   = 3'd4;
    localparam logic [2:0] S_QX   = 3'd5;
    localparam logic [2:0] S_DY   = 3'd6;
    localparam logic [2:0] S_QY   = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_pend_reg, out_pend_next;
    logic [15:0] prev_reg;

    logic [7:0]  rx_reg, ry_reg;
    logic [15:0] btn_reg, prs_reg;
    logic [6:0]  ax_reg, ay_reg;
    logic        sx_reg, sy_reg;
    logic [13:0] sqx_reg, sqy_reg;
    logic [14:0] sum_reg;
    logic [14:0] mx_reg, my_reg, mag_reg;

    logic [7:0]  o_rx_reg, o_ry_reg;
    logic [15:0] o_ex_reg, o_ey_reg;
    logic [14:0] o_mag_reg;
    logic [15:0] o_prs_reg, o_btn_reg;

    jdc_pkg::jdc_cmd_t  eng_cmd;
    jdc_pkg::jdc_stat_t eng_stat;
    logic [28:0]        eng_a;
    logic [28:0]        eng_res;

    logic in_acc;
    logic over;
    logic out_load;

    assign in_stall = (state_reg != S_IDLE) || out_pend_reg;
    assign in_acc   = in_valid && !in_stall;
    assign over     = (sum_reg > 15'(jdc_pkg::MAG_LIMIT_SQ));
    assign out_load = out_pend_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        eng_cmd.start   = 1'b0;
        eng_cmd.op_sqrt = 1'b0;
        eng_a           = '0;
        state_next      = state_reg;
        out_pend_next   = out_pend_reg && !out_load;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                eng_cmd.start   = 1'b1;
                eng_cmd.op_sqrt = !over;
                eng_a           = over ? {15'd0, sqx_reg} : {sum_reg[12:0], 16'd0};
                state_next      = over ? S_DX : S_MAG;
            end
            S_MAG:
            begin
                if (eng_stat.done)
                begin
                    out_pend_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DX:
            begin
                if (eng_stat.done)
                begin
                    eng_cmd.start   = 1'b1;
                    eng_cmd.op_sqrt = 1'b1;
                    eng_a           = eng_res;
                    state_next      = S_QX;
                end
            end
            S_QX:
            begin
                if (eng_stat.done)
                begin
                    eng_cmd.start = 1'b1;
                    eng_a         = {15'd0, sqy_reg};
                    state_next    = S_DY;
                end
            end
            S_DY:
            begin
                if (eng_stat.done)
                begin
                    eng_cmd.start   = 1'b1;
                    eng_cmd.op_sqrt = 1'b1;
                    eng_a           = eng_res;
                    state_next      = S_QY;
                end
            end
            S_QY:
            begin
                if (eng_stat.done)
                begin
                    out_pend_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    jdc_divsqrt u_divsqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (eng_cmd),
        .opnd_a (eng_a),
        .opnd_d (sum_reg),
        .stat   (eng_stat),
        .result (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_pend_reg  <= 1'b0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_pend_reg  <= out_pend_next;
            if (in_acc)
            begin
                prev_reg <= buttons;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rx_reg  <= stick_x;
            ry_reg  <= stick_y;
            btn_reg <= buttons;
            prs_reg <= buttons & (buttons ^ prev_reg);
            ax_reg  <= jdc_pkg::dz_mag(stick_x);
            ay_reg  <= jdc_pkg::dz_mag(stick_y);
            sx_reg  <= stick_x[7];
            sy_reg  <= stick_y[7];
        end
        if (state_reg == S_SUM)
        begin
            sqx_reg <= 14'(ax_reg) * 14'(ax_reg);
            sqy_reg <= 14'(ay_reg) * 14'(ay_reg);
            sum_reg <= 15'(ax_reg) * 15'(ax_reg) + 15'(ay_reg) * 15'(ay_reg);
        end
        if (state_reg == S_CHK && !over)
        begin
            mx_reg <= {ax_reg, 8'd0};
            my_reg <= {ay_reg, 8'd0};
        end
        if (state_reg == S_MAG && eng_stat.done)
        begin
            mag_reg <= eng_res[14:0];
        end
        if (state_reg == S_QX && eng_stat.done)
        begin
            mx_reg <= eng_res[14:0];
        end
        if (state_reg == S_QY && eng_stat.done)
        begin
            my_reg  <= eng_res[14:0];
            mag_reg <= 15'(jdc_pkg::MAG_Q);
        end
        if (out_load)
        begin
            o_rx_reg  <= rx_reg;
            o_ry_reg  <= ry_reg;
            o_ex_reg  <= sx_reg ? -{1'b0, mx_reg} : {1'b0, mx_reg};
            o_ey_reg  <= sy_reg ? -{1'b0, my_reg} : {1'b0, my_reg};
            o_mag_reg <= mag_reg;
            o_prs_reg <= prs_reg;
            o_btn_reg <= btn_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign raw_x     = o_rx_reg;
    assign raw_y     = o_ry_reg;
    assign eff_x     = o_ex_reg;
    assign eff_y     = o_ey_reg;
    assign magnitude = o_mag_reg;
    assign pressed   = o_prs_reg;
    assign held      = o_btn_reg;

`ifndef SYNTHESIS
    a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> magnitude <= 15'(jdc_pkg::MAG_Q))
        else $error("magnitude beyond limit");
    a_dead_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && raw_x >= -8'sd7 && raw_x <= 8'sd7 |-> eff_x == 16'sd0)
        else $error("dead zone x not zero");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("beat taken while previous poll in flight");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for joystick_deadzone_clamp_core: a directed set of stick polls, then random
// ones, driven in bursts against a stalling receiver and checked against a local predictor.
// Depends only on the RTL of the block.
module tb_top;

    localparam int EDGE_IN       = 8;
    localparam int EDGE_SHIFT    = 6;
    localparam int CLAMP_RADIUS  = 64;
    localparam int FRAC          = 8;
    localparam int RANDOM_POLLS  = 600;
    localparam int TAIL_CYCLES   = 150;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct {
        logic signed [7:0] sx;
        logic signed [7:0] sy;
        logic [15:0]       btn;
    } poll_beat_t;

    typedef struct {
        logic signed [7:0]  raw_x;
        logic signed [7:0]  raw_y;
        logic signed [15:0] eff_x;
        logic signed [15:0] eff_y;
        logic [14:0]        mag;
        logic [15:0]        pressed;
        logic [15:0]        held;
    } stick_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [7:0]  stick_x;
    logic signed [7:0]  stick_y;
    logic [15:0]        buttons;
    logic               out_valid;
    logic               out_stall;
    logic signed [7:0]  raw_x;
    logic signed [7:0]  raw_y;
    logic signed [15:0] eff_x;
    logic signed [15:0] eff_y;
    logic [14:0]        magnitude;
    logic [15:0]        pressed;
    logic [15:0]        held;

    poll_beat_t    polls_pending[$];
    stick_result_t results_due[$];
    logic [15:0]   last_buttons = '0;
    logic          in_taken = 1'b0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            burst_left = 1;
    int            gap_left = 0;
    int            stall_mode = 0;
    int            stall_tick = 0;
    logic [31:0]   stall_word = '0;

    joystick_deadzone_clamp_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .stick_x   (stick_x),
        .stick_y   (stick_y),
        .buttons   (buttons),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .eff_x     (eff_x),
        .eff_y     (eff_y),
        .magnitude (magnitude),
        .pressed   (pressed),
        .held      (held)
    );

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v)
        begin
            probe = probe >> 2;
        end
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic int shrink_axis(input logic signed [7:0] v);
        int s;
        s = v;
        if (s <= -EDGE_IN)
        begin
            return s + EDGE_SHIFT;
        end
        if (s >= EDGE_IN)
        begin
            return s - EDGE_SHIFT;
        end
        return 0;
    endfunction

    function automatic stick_result_t predict_poll(input poll_beat_t p, input logic [15:0] prev);
        stick_result_t   r;
        int              ex;
        int              ey;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned sum;
        longint unsigned scale;
        longint unsigned qx;
        longint unsigned qy;
        ex  = shrink_axis(p.sx);
        ey  = shrink_axis(p.sy);
        ax  = (ex < 0) ? -ex : ex;
        ay  = (ey < 0) ? -ey : ey;
        sum = ax * ax + ay * ay;
        r.raw_x   = p.sx;
        r.raw_y   = p.sy;
        r.held    = p.btn;
        r.pressed = p.btn & (p.btn ^ prev);
        if (sum > CLAMP_RADIUS * CLAMP_RADIUS)
        begin
            scale   = CLAMP_RADIUS << FRAC;
            qx      = floor_root((ax * ax * scale * scale) / sum);
            qy      = floor_root((ay * ay * scale * scale) / sum);
            r.eff_x = (ex < 0) ? -16'(qx) : 16'(qx);
            r.eff_y = (ey < 0) ? -16'(qy) : 16'(qy);
            r.mag   = 15'(scale);
        end
        else
        begin
            r.eff_x = 16'(ex * (1 << FRAC));
            r.eff_y = 16'(ey * (1 << FRAC));
            r.mag   = 15'(floor_root(sum << (2 * FRAC)));
        end
        return r;
    endfunction

    // raw stick value that conditions to e (e of 0 or 1 lands in the dead zone)
    function automatic logic signed [7:0] raw_for(input int e);
        int m;
        if (e <= 1)
        begin
            m = int'($urandom_range(0, 14)) - 7;
        end
        else
        begin
            m = e + EDGE_SHIFT;
            if ($urandom_range(0, 1) == 1)
            begin
                m = -m;
            end
        end
        return 8'(m);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    task automatic add_poll(input int x, input int y, input logic [15:0] btn);
        poll_beat_t p;
        p.sx  = 8'(x);
        p.sy  = 8'(y);
        p.btn = btn;
        polls_pending.push_back(p);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("joystick_deadzone_clamp_core verification failed");
            $finish;
        end
    end

    // sender: bursts of beats separated by idle gaps; a stalled beat is held
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (polls_pending.size() > 0)
            begin
                stick_x  <= polls_pending[0].sx;
                stick_y  <= polls_pending[0].sy;
                buttons  <= polls_pending[0].btn;
                in_valid <= 1'b1;
                void'(polls_pending.pop_front());
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: mode and pattern word are redrawn periodically; the word rotates in between
    always @(negedge clk)
    begin
        stall_tick = stall_tick + 1;
        if (stall_tick % 64 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_word <= $urandom;
        end
        else
        begin
            stall_word <= {stall_word[0], stall_word[31:1]};
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= stall_word[0];
            2: out_stall <= stall_word[0] & stall_word[5];
            default: out_stall <= stall_word[0] | stall_word[9];
        endcase
    end

    always @(posedge clk)
    begin
        stick_result_t want;
        poll_beat_t    p;
        in_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            p.sx  = stick_x;
            p.sy  = stick_y;
            p.btn = buttons;
            results_due.push_back(predict_poll(p, last_buttons));
            last_buttons = buttons;
        end
        if (out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                flag_mismatch("result beat with none due", 1, 0);
            end
            else
            begin
                want = results_due.pop_front();
                if (raw_x !== want.raw_x)
                    flag_mismatch("raw_x", int'(raw_x), int'(want.raw_x));
                if (raw_y !== want.raw_y)
                    flag_mismatch("raw_y", int'(raw_y), int'(want.raw_y));
                if (eff_x !== want.eff_x)
                    flag_mismatch("eff_x", int'(eff_x), int'(want.eff_x));
                if (eff_y !== want.eff_y)
                    flag_mismatch("eff_y", int'(eff_y), int'(want.eff_y));
                if (magnitude !== want.mag)
                    flag_mismatch("magnitude", int'(magnitude), int'(want.mag));
                if (pressed !== want.pressed)
                    flag_mismatch("pressed", int'(pressed), int'(want.pressed));
                if (held !== want.held)
                    flag_mismatch("held", int'(held), int'(want.held));
            end
        end
    end

    initial
    begin
        int          kind;
        int          ex;
        int          ey;
        int          t;
        logic [15:0] gen_btn;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        stick_x   = '0;
        stick_y   = '0;
        buttons   = '0;

        // first poll after reset: every held bit is new
        add_poll(0, 0, 16'hA5C3);
        add_poll(0, 0, 16'hA5C3);
        add_poll(127, 127, 16'hFFFF);
        add_poll(-128, -128, 16'h0000);
        add_poll(-128, 127, 16'h5555);
        add_poll(127, -128, 16'hAAAA);
        add_poll(7, -7, 16'hFFFF);
        add_poll(-7, 7, 16'h0001);
        add_poll(8, 0, 16'h8000);
        add_poll(-8, 0, 16'h8001);
        add_poll(0, 8, 16'h0000);
        add_poll(0, -8, 16'h1234);
        add_poll(70, 0, 16'hEDCB);
        add_poll(0, -70, 16'hEDCB);
        add_poll(-70, 8, 16'h00FF);
        add_poll(54, 54, 16'hFF00);
        add_poll(52, -52, 16'h0F0F);
        add_poll(127, 0, 16'hF0F0);
        add_poll(0, -128, 16'h7FFF);
        add_poll(9, -9, 16'hFFFE);

        gen_btn = 16'h7FFF;
        repeat (RANDOM_POLLS)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                ex = int'($urandom_range(0, 255)) - 128;
                ey = int'($urandom_range(0, 255)) - 128;
            end
            else if (kind <= 4)
            begin
                ex = int'($urandom_range(0, 20)) - 10;
                ey = int'($urandom_range(0, 20)) - 10;
            end
            else if (kind <= 6)
            begin
                t  = $urandom_range(0, CLAMP_RADIUS);
                ey = int'(floor_root(CLAMP_RADIUS * CLAMP_RADIUS - t * t))
                     + int'($urandom_range(0, 2)) - 1;
                if (ey < 0)
                begin
                    ey = 0;
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    ex = raw_for(t);
                    ey = raw_for(ey);
                end
                else
                begin
                    ex = raw_for(ey);
                    ey = raw_for(t);
                end
            end
            else
            begin
                ex = ($urandom_range(0, 1) == 1) ? -128 + int'($urandom_range(0, 1))
                                                 : 127 - int'($urandom_range(0, 1));
                ey = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 255)) - 128;
                if ($urandom_range(0, 1) == 1)
                begin
                    t  = ex;
                    ex = ey;
                    ey = t;
                end
            end
            case ($urandom_range(0, 7))
                0: gen_btn = 16'($urandom);
                1: gen_btn = 16'h0000;
                2: gen_btn = 16'hFFFF;
                3: gen_btn = gen_btn;
                default:
                begin
                    gen_btn = gen_btn ^ (16'd1 << $urandom_range(0, 15));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        gen_btn = gen_btn ^ (16'd1 << $urandom_range(0, 15));
                    end
                end
            endcase
            add_poll(ex, ey, gen_btn);
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        @(posedge clk);
        while (polls_pending.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        while (results_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && results_due.size() == 0)
        begin
            $display("joystick_deadzone_clamp_core verification clean");
        end
        else
        begin
            $display("joystick_deadzone_clamp_core verification failed");
        end
        $finish;
    end

endmodule
